>>> sv/mvma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvma_pkg: shared types and constants
// Field widths, opcodes, register indexes and accumulator sizing for the
// matrix-vector multiply-accumulate block.
// ----------------------------------------------------------------------------
package mvma_pkg;

    localparam int VAL_W     = 16;
    localparam int IDX_W     = 6;
    localparam int DIM_W     = 7;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 3;
    localparam int FRAC      = 12;
    localparam int PROD_W    = 2 * VAL_W;
    // exact sum of up to 256 full-scale products
    localparam int ACC_W     = 40;
    localparam int SUM_W     = ACC_W - FRAC;

    localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_X  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_Y  = 2'd2;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRANS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd4;

    // controls broadcast to every cell
    typedef struct packed {
        logic mode_t;     // 1: transpose, cells accumulate locally
        logic acc_en;     // product register holds a valid transpose term
        logic acc_first;  // that term starts a new sum
    } t_cell_ctl;

    typedef struct packed {
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] val;
        logic                    last;
    } t_result;

endpackage

>>> sv/mvma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvma_if: channel interfaces
// Input item, result item and configuration write channels.
// ----------------------------------------------------------------------------
interface mvma_in_if;
    import mvma_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] value;
    modport source (output valid, opcode, row_index, col_index, value, input ready);
    modport sink (input valid, opcode, row_index, col_index, value, output ready);
endinterface

interface mvma_out_if;
    import mvma_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
    modport source (output valid, out_index, out_value, last, input ready);
    modport sink (input valid, out_index, out_value, last, output ready);
endinterface

interface mvma_cfg_if;
    import mvma_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [VAL_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/mvma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvma_cell: one column cell
// Holds one matrix column in a local bank and one x element. Row mode adds
// its term to the partial sum passing along the chain; transpose mode
// accumulates its own column dot product.
// ----------------------------------------------------------------------------
module mvma_cell import mvma_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_a_we,
    input  logic [AW-1:0]           i_a_waddr,
    input  logic signed [VAL_W-1:0] i_a_wdata,
    input  logic                    i_x_we,
    input  logic signed [VAL_W-1:0] i_x_wdata,
    input  t_cell_ctl               i_ctl,
    input  logic                    i_en,
    input  logic [AW-1:0]           i_bc_addr,
    input  logic signed [VAL_W-1:0] i_bc_x,
    input  logic                    i_v,
    input  logic [AW-1:0]           i_addr,
    input  logic signed [ACC_W-1:0] i_psum,
    output logic                    o_v,
    output logic [AW-1:0]           o_addr,
    output logic signed [ACC_W-1:0] o_psum,
    output logic signed [ACC_W-1:0] o_acc
);

    logic signed [VAL_W-1:0]  r_bank [DEPTH];
    logic signed [VAL_W-1:0]  r_rdata;
    logic signed [VAL_W-1:0]  r_x;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  r_ps1, r_ps2, r_ps3;
    logic [AW-1:0]            r_a1, r_a2, r_a3;
    logic                     r_v1, r_v2, r_v3;
    logic [AW-1:0]            w_rd_addr;
    logic signed [VAL_W-1:0]  w_mult;

    assign w_rd_addr = i_ctl.mode_t ? i_bc_addr : i_addr;
    assign w_mult    = i_ctl.mode_t ? i_bc_x : r_x;

    always_ff @(posedge i_clk) begin
        if (i_a_we) begin
            r_bank[i_a_waddr] <= i_a_wdata;
        end
        r_rdata <= r_bank[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_x_we) begin
            r_x <= i_x_wdata;
        end
        // unused columns contribute nothing
        r_prod <= i_en ? r_rdata * w_mult : PROD_W'(0);
        r_a1   <= i_addr;
        r_a2   <= r_a1;
        r_a3   <= r_a2;
        r_ps1  <= i_psum;
        r_ps2  <= r_ps1;
        r_ps3  <= r_ps2 + ACC_W'(r_prod);
        if (i_ctl.acc_en) begin
            r_acc <= (i_ctl.acc_first ? '0 : r_acc) + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_v    = r_v3;
    assign o_addr = r_a3;
    assign o_psum = r_ps3;
    assign o_acc  = r_acc;

endmodule

>>> sv/mvma_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvma_scale: alpha/beta scaling and y store
// Truncates the dot product to Q.12, forms alpha*s + beta*y with arithmetic
// shifts, saturates to 16 bits and writes the new y element back.
// ----------------------------------------------------------------------------
module mvma_scale import mvma_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_y_we,
    input  logic [AW-1:0]           i_y_waddr,
    input  logic signed [VAL_W-1:0] i_y_wdata,
    input  logic signed [VAL_W-1:0] i_alpha,
    input  logic signed [VAL_W-1:0] i_beta,
    input  logic                    i_v,
    input  logic [AW-1:0]           i_idx,
    input  logic                    i_last,
    input  logic signed [ACC_W-1:0] i_acc,
    output logic                    o_v,
    output logic [AW-1:0]           o_idx,
    output logic signed [VAL_W-1:0] o_val,
    output logic                    o_last
);

    localparam int PA_W = VAL_W + SUM_W;
    localparam int SW   = PA_W - FRAC + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

    logic signed [VAL_W-1:0]  r_y [DEPTH];
    logic signed [VAL_W-1:0]  r_y1;
    logic signed [ACC_W-1:0]  r_acc1;
    logic signed [PA_W-1:0]   r_pa;
    logic signed [PROD_W-1:0] r_pb;
    logic [AW-1:0]            r_k1, r_k2, r_k3;
    logic                     r_l1, r_l2, r_l3;
    logic                     r_v1, r_v2, r_v3;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [SUM_W-1:0]  w_s;
    logic signed [SW-1:0]     w_sum;
    logic signed [VAL_W-1:0]  w_sat;

    assign w_s   = SUM_W'(r_acc1 >>> FRAC);
    assign w_sum = SW'(r_pa >>> FRAC) + SW'(r_pb >>> FRAC);

    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = 16'sh7fff;
        end else if (w_sum < SAT_LO) begin
            w_sat = -16'sh8000;
        end else begin
            w_sat = VAL_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_y[r_k2] <= w_sat;
        end else if (i_y_we) begin
            r_y[i_y_waddr] <= i_y_wdata;
        end
        r_y1 <= r_y[i_idx];
    end

    always_ff @(posedge i_clk) begin
        r_acc1 <= i_acc;
        r_k1   <= i_idx;
        r_l1   <= i_last;
        r_pa   <= i_alpha * w_s;
        r_pb   <= i_beta * r_y1;
        r_k2   <= r_k1;
        r_l2   <= r_l1;
        r_k3   <= r_k2;
        r_l3   <= r_l2;
        r_val  <= w_sat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_v;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_v    = r_v3;
    assign o_idx  = r_k3;
    assign o_val  = r_val;
    assign o_last = r_l3;

endmodule

>>> sv/matrix_vector_multiply_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_vector_multiply_accumulate: y = alpha*op(A)*x + beta*y
// Chain of MAX_DIM column cells, a scaling stage and a result queue.
// ----------------------------------------------------------------------------
// Load items (A, x, y entries) may follow back to back. A compute item
// runs one pass over the cell chain, one matrix column per cell: in row
// mode the row partial sums walk the chain; in transpose mode every cell
// accumulates its column over the rows and the sums are then read out one
// per cycle. No item is taken during a pass.
// Results go to a MAX_DIM-deep queue; loads are accepted while it drains,
// a compute item waits until it is empty. No clearing pass after reset.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_accumulate import mvma_pkg::*; #(
    parameter int MAX_DIM = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mvma_cfg_if.sink     i_cfg,
    mvma_in_if.sink      i_in,
    mvma_out_if.source   o_out
);

    localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CW = $clog2(MAX_DIM + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FLUSH = 3'd4;

    logic [DIM_W-1:0]        r_rows, r_cols;
    logic                    r_trans;
    logic signed [VAL_W-1:0] r_alpha, r_beta;

    logic [2:0]              r_state;
    logic [CW-1:0]           r_cnt, r_len, r_outer, r_done;
    logic                    r_wait;
    logic [CW-1:0]           w_m, w_n, w_outer;
    logic                    w_acc, w_cfg;
    logic [AW-1:0]           w_ridx;

    logic signed [VAL_W-1:0] r_xmem [MAX_DIM];
    logic signed [VAL_W-1:0] r_bc_x;
    logic                    r_bc_v1, r_bc_v2, r_bc_f1, r_bc_f2;
    t_cell_ctl               w_ctl;
    logic                    w_issue, w_drain;

    logic                    c_v    [MAX_DIM+1];
    logic [AW-1:0]           c_addr [MAX_DIM+1];
    logic signed [ACC_W-1:0] c_psum [MAX_DIM+1];
    logic signed [ACC_W-1:0] c_acc  [MAX_DIM];

    logic                    r_dr_v;
    logic [AW-1:0]           r_dr_k;
    logic signed [ACC_W-1:0] r_dr_acc;
    logic                    w_sc_v, w_sc_last;
    logic [AW-1:0]           w_sc_idx;
    logic signed [ACC_W-1:0] w_sc_acc;
    logic                    s_v, s_last;
    logic [AW-1:0]           s_idx;
    logic signed [VAL_W-1:0] s_val;

    t_result                 r_fmem [MAX_DIM];
    t_result                 r_o;
    logic                    r_ov;
    logic [AW-1:0]           r_wp, r_rp;
    logic [CW-1:0]           r_fcnt;
    logic                    w_pop;

    // ---------------- configuration ----------------
    assign i_cfg.ready = (r_state == ST_IDLE);
    assign w_cfg       = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows  <= DIM_W'(1);
            r_cols  <= DIM_W'(1);
            r_trans <= 1'b0;
            r_alpha <= 16'sd4096;
            r_beta  <= '0;
        end else if (w_cfg) begin
            case (i_cfg.index)
                REG_ROWS:  r_rows  <= i_cfg.data[DIM_W-1:0];
                REG_COLS:  r_cols  <= i_cfg.data[DIM_W-1:0];
                REG_TRANS: r_trans <= i_cfg.data[0];
                REG_ALPHA: r_alpha <= i_cfg.data;
                REG_BETA:  r_beta  <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    assign w_m     = (r_rows > MAX_DIM) ? CW'(MAX_DIM) : CW'(r_rows);
    assign w_n     = (r_cols > MAX_DIM) ? CW'(MAX_DIM) : CW'(r_cols);
    assign w_outer = r_trans ? w_n : w_m;

    // ---------------- input channel ----------------
    assign i_in.ready = (r_state == ST_IDLE) &&
                        ((i_in.opcode != OP_COMPUTE) || (r_fcnt == '0));
    assign w_acc  = i_in.valid && i_in.ready;
    assign w_ridx = AW'(i_in.row_index);

    always_ff @(posedge i_clk) begin
        if (w_acc && i_in.opcode == OP_LOAD_X && i_in.row_index < MAX_DIM) begin
            r_xmem[w_ridx] <= i_in.value;
        end
        r_bc_x <= r_xmem[r_cnt[AW-1:0]];
    end

    // ---------------- sequencer ----------------
    assign w_issue = (r_state == ST_ISSUE);
    assign w_drain = (r_state == ST_DRAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_len   <= '0;
            r_outer <= '0;
            r_done  <= '0;
            r_wait  <= 1'b0;
        end else begin
            if (s_v) begin
                r_done <= r_done + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_acc && i_in.opcode == OP_COMPUTE && w_m != '0 && w_n != '0) begin
                        r_state <= ST_ISSUE;
                        r_cnt   <= '0;
                        r_len   <= w_m;
                        r_outer <= w_outer;
                        r_done  <= '0;
                    end
                end
                ST_ISSUE: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_len - 1'b1) begin
                        r_cnt   <= '0;
                        r_wait  <= 1'b0;
                        r_state <= r_trans ? ST_WAIT : ST_FLUSH;
                    end
                end
                ST_WAIT: begin
                    // let the last transpose term reach the accumulators
                    r_wait <= 1'b1;
                    if (r_wait) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == r_outer - 1'b1) begin
                        r_cnt   <= '0;
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (r_done == r_outer) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc_v1 <= 1'b0;
            r_bc_v2 <= 1'b0;
            r_dr_v  <= 1'b0;
        end else begin
            r_bc_v1 <= w_issue && r_trans;
            r_bc_v2 <= r_bc_v1;
            r_dr_v  <= w_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bc_f1  <= (r_cnt == '0);
        r_bc_f2  <= r_bc_f1;
        r_dr_k   <= r_cnt[AW-1:0];
        r_dr_acc <= c_acc[r_cnt[AW-1:0]];
    end

    assign w_ctl.mode_t    = r_trans;
    assign w_ctl.acc_en    = r_bc_v2;
    assign w_ctl.acc_first = r_bc_f2;

    // ---------------- cell chain ----------------
    assign c_v[0]    = w_issue && !r_trans;
    assign c_addr[0] = r_cnt[AW-1:0];
    assign c_psum[0] = '0;

    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        mvma_cell #(
            .DEPTH(MAX_DIM),
            .AW   (AW)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_a_we   (w_acc && i_in.opcode == OP_LOAD_A &&
                       i_in.row_index < MAX_DIM && i_in.col_index == c),
            .i_a_waddr(w_ridx),
            .i_a_wdata(i_in.value),
            .i_x_we   (w_acc && i_in.opcode == OP_LOAD_X && i_in.row_index == c),
            .i_x_wdata(i_in.value),
            .i_ctl    (w_ctl),
            .i_en     (c < w_n),
            .i_bc_addr(r_cnt[AW-1:0]),
            .i_bc_x   (r_bc_x),
            .i_v      (c_v[c]),
            .i_addr   (c_addr[c]),
            .i_psum   (c_psum[c]),
            .o_v      (c_v[c+1]),
            .o_addr   (c_addr[c+1]),
            .o_psum   (c_psum[c+1]),
            .o_acc    (c_acc[c])
        );
    end

    // ---------------- scaling ----------------
    assign w_sc_v    = r_trans ? r_dr_v : c_v[MAX_DIM];
    assign w_sc_idx  = r_trans ? r_dr_k : c_addr[MAX_DIM];
    assign w_sc_acc  = r_trans ? r_dr_acc : c_psum[MAX_DIM];
    assign w_sc_last = (CW'(w_sc_idx) == r_outer - 1'b1);

    mvma_scale #(
        .DEPTH(MAX_DIM),
        .AW   (AW)
    ) u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_y_we   (w_acc && i_in.opcode == OP_LOAD_Y && i_in.row_index < MAX_DIM),
        .i_y_waddr(w_ridx),
        .i_y_wdata(i_in.value),
        .i_alpha  (r_alpha),
        .i_beta   (r_beta),
        .i_v      (w_sc_v),
        .i_idx    (w_sc_idx),
        .i_last   (w_sc_last),
        .i_acc    (w_sc_acc),
        .o_v      (s_v),
        .o_idx    (s_idx),
        .o_val    (s_val),
        .o_last   (s_last)
    );

    // ---------------- result queue ----------------
    assign w_pop = (r_fcnt != '0) && (!r_ov || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (s_v) begin
            r_fmem[r_wp] <= '{idx: IDX_W'(s_idx), val: s_val, last: s_last};
        end
        if (w_pop) begin
            r_o <= r_fmem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (s_v) begin
                r_wp <= (r_wp == AW'(MAX_DIM - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(MAX_DIM - 1)) ? '0 : r_rp + 1'b1;
            end
            r_fcnt <= r_fcnt + CW'(s_v) - CW'(w_pop);
            if (w_pop) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_index = r_o.idx;
    assign o_out.out_value = r_o.val;
    assign o_out.last      = r_o.last;

`ifndef SYNTHESIS
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= CW'(MAX_DIM))
        else $error("result queue overfilled");
    a_push_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_v |-> r_state != ST_IDLE)
        else $error("result produced while idle");
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_done <= r_outer)
        else $error("more results than vector length");
    a_tail_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_v[MAX_DIM] |-> !r_trans && (r_state == ST_ISSUE || r_state == ST_FLUSH))
        else $error("chain output outside a row-mode pass");
`endif

endmodule
